// ===== rtl/rat_pkg.sv =====
package rat_pkg;

  // payload widths of the channels
  localparam int KIND_W     = 3;
  localparam int KEY_W      = 10;
  localparam int SCOUNT_W   = 11;
  localparam int SLOT_IDX_W = 6;
  localparam int STATUS_W   = 3;
  localparam int TBL_LEN_W  = 7;
  localparam int SLOT_CNT_W = 16;

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_ADD_GEN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_SURF  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_BONE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND_BONE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FIND_SURF = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SURF_RANGE = 3'd4;

  // flags from the slot compare unit
  typedef struct packed {
    logic hit;
    logic free;
  } rat_eval_t;

endpackage

// ===== rtl/rat_if.sv =====
interface rat_in_if import rat_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [KEY_W-1:0]      key;
  logic [SCOUNT_W-1:0]   surface_count;
  logic                  require_generated;
  logic [SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, kind, key, surface_count, require_generated, slot_index,
                  input ready);
  modport sink   (input valid, kind, key, surface_count, require_generated, slot_index,
                  output ready);
endinterface

interface rat_out_if import rat_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_IDX_W-1:0] result_index;
  logic [TBL_LEN_W-1:0]  table_length;
  logic [SLOT_CNT_W-1:0] slot_count;

  modport source (output valid, status, result_index, table_length, slot_count,
                  input ready);
  modport sink   (input valid, status, result_index, table_length, slot_count,
                  output ready);
endinterface

// ===== rtl/rat_ram.sv =====
module rat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rat_slot_eval.sv =====
// Shared compare/count unit: judges one slot word read from the table.
// Word layout (msb..lsb): bone_present, surface_present, generated, key, count.
module rat_slot_eval import rat_pkg::*; #(
  parameter int KEY_BITS   = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic [KEY_BITS+COUNT_BITS+2:0] slot_word,
  input  logic [KEY_BITS-1:0]            key,
  input  logic                           is_bone,
  input  logic                           need_gen,
  output rat_eval_t                      flags,
  output logic [COUNT_BITS-1:0]          cnt_inc,
  output logic [COUNT_BITS-1:0]          cnt_dec
);

  localparam int W = KEY_BITS + COUNT_BITS + 3;

  logic                  bone_p;
  logic                  surf_p;
  logic                  gen;
  logic [KEY_BITS-1:0]   skey;
  logic [COUNT_BITS-1:0] cnt;
  logic                  key_eq;

  assign bone_p = slot_word[W-1];
  assign surf_p = slot_word[W-2];
  assign gen    = slot_word[W-3];
  assign skey   = slot_word[COUNT_BITS +: KEY_BITS];
  assign cnt    = slot_word[COUNT_BITS-1:0];
  assign key_eq = (skey == key);

  always_comb begin
    flags.free = !bone_p && !surf_p;
    if (is_bone) begin
      flags.hit = bone_p && key_eq;
    end else begin
      flags.hit = surf_p && key_eq && (!need_gen || gen);
    end
  end

  // saturating increment, floored decrement
  assign cnt_inc = (&cnt) ? cnt : cnt + COUNT_BITS'(1);
  assign cnt_dec = (cnt == '0) ? cnt : cnt - COUNT_BITS'(1);

endmodule

// ===== rtl/refcounted_attach_table_core.sv =====
// Sequence: add/find scan the live slots in order and stop early on a hit; remove reads the
//   slot and writes back the decremented count, then trims the free tail when the slot frees;
//   clear, surface-range and bad-kind rejects go straight to the output register.
// Throughput: one operation at a time; the single table read port scans one slot per cycle.
// Reset: rst_n synchronous, active low; clears the live length, sequencer and output valid.
//   Slot contents are not cleared, as nothing at or above the live length is ever read.
module refcounted_attach_table_core import rat_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  rat_in_if.sink   in_ch,
  rat_out_if.source out_ch
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LEN_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = KEY_BITS + COUNT_BITS + 3;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RM_RD   = 3'd2;
  localparam logic [2:0] S_RM_EVAL = 3'd3;
  localparam logic [2:0] S_TRIM    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_r, state_nxt;

  // latched operation
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic                  req_gen_r, req_gen_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;

  // table length and scan bookkeeping
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] ra_r, ra_nxt;      // scan: next slot to read; trim: slots left
  logic             pend_r, pend_nxt;  // a read is in flight
  logic [IDX_W-1:0] pidx_r, pidx_nxt;  // slot of the read in flight
  logic             ffv_r, ffv_nxt;    // first free slot seen
  logic [IDX_W-1:0] ff_r, ff_nxt;

  // result held until the output register is free
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic [IDX_W-1:0]      res_idx_r, res_idx_nxt;
  logic [COUNT_BITS-1:0] res_cnt_r, res_cnt_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_st_r, out_st_nxt;
  logic [SLOT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [TBL_LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [SLOT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // table port
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;

  // compare unit
  rat_eval_t             ev;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  is_bone;
  logic                  is_add;
  logic                  need_gen;
  logic [WORD_W-1:0]     new_word;
  logic [KEY_BITS-1:0]   in_key;
  logic                  stop;

  assign in_key   = KEY_BITS'(in_ch.key);
  assign is_bone  = (kind_r == KIND_ADD_BONE) || (kind_r == KIND_FIND_BONE);
  assign is_add   = (kind_r == KIND_ADD_GEN) || (kind_r == KIND_ADD_SURF) ||
                    (kind_r == KIND_ADD_BONE);
  assign need_gen = (kind_r == KIND_FIND_SURF) && req_gen_r;
  // fresh slot: one user, generated mark only for generated surface adds
  assign new_word = {is_bone, !is_bone, kind_r == KIND_ADD_GEN, key_r, COUNT_BITS'(1)};

  rat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rat_slot_eval #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .slot_word (rdata),
    .key       (key_r),
    .is_bone   (is_bone),
    .need_gen  (need_gen),
    .flags     (ev),
    .cnt_inc   (cnt_inc),
    .cnt_dec   (cnt_dec)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.table_length = out_len_r;
  assign out_ch.slot_count   = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    req_gen_nxt   = req_gen_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    ra_nxt        = ra_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    ffv_nxt       = ffv_r;
    ff_nxt        = ff_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_idx_nxt   = out_idx_r;
    out_len_nxt   = out_len_r;
    out_cnt_nxt   = out_cnt_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;
    stop          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt    = in_ch.kind;
          key_nxt     = in_key;
          req_gen_nxt = in_ch.require_generated;
          idx_nxt     = in_ch.slot_index;
          res_st_nxt  = ST_OK;
          res_idx_nxt = '0;
          res_cnt_nxt = '0;
          ra_nxt      = '0;
          pend_nxt    = 1'b0;
          ffv_nxt     = 1'b0;
          unique case (in_ch.kind)
            KIND_ADD_GEN: begin
              if (17'(in_key) >= 17'(in_ch.surface_count)) begin
                res_st_nxt = ST_SURF_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_ADD_SURF, KIND_ADD_BONE, KIND_FIND_BONE, KIND_FIND_SURF: begin
              state_nxt = S_SCAN;
            end
            KIND_REMOVE: begin
              if (16'(in_ch.slot_index) >= 16'(len_r)) begin
                res_st_nxt = ST_BAD_INDEX;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RM_RD;
              end
            end
            KIND_CLEAR: begin
              len_nxt   = '0;
              state_nxt = S_DONE;
            end
            default: begin
              res_st_nxt = ST_BAD_INDEX;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      // one slot read per cycle; the word read last cycle is judged this cycle
      S_SCAN: begin
        if (pend_r && ev.hit) begin
          res_st_nxt  = ST_OK;
          res_idx_nxt = pidx_r;
          if (is_add) begin
            we          = 1'b1;
            waddr       = pidx_r;
            wdata       = {rdata[WORD_W-1:COUNT_BITS], cnt_inc};
            res_cnt_nxt = cnt_inc;
          end else begin
            res_cnt_nxt = rdata[COUNT_BITS-1:0];
          end
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          if (pend_r && ev.free && !ffv_r) begin
            ffv_nxt = 1'b1;
            ff_nxt  = pidx_r;
          end
          if (ra_r < len_r) begin
            re       = 1'b1;
            raddr    = ra_r[IDX_W-1:0];
            pend_nxt = 1'b1;
            pidx_nxt = ra_r[IDX_W-1:0];
            ra_nxt   = ra_r + LEN_W'(1);
          end else if (!pend_r) begin
            // scan exhausted without a match
            state_nxt = S_DONE;
            if (!is_add) begin
              res_st_nxt = ST_NOT_FOUND;
            end else if (ffv_r) begin
              we          = 1'b1;
              waddr       = ff_r;
              wdata       = new_word;
              res_idx_nxt = ff_r;
              res_cnt_nxt = COUNT_BITS'(1);
            end else if (len_r >= LEN_W'(ENTRIES)) begin
              res_st_nxt = ST_FULL;
            end else begin
              we          = 1'b1;
              waddr       = len_r[IDX_W-1:0];
              wdata       = new_word;
              res_idx_nxt = len_r[IDX_W-1:0];
              res_cnt_nxt = COUNT_BITS'(1);
              len_nxt     = len_r + LEN_W'(1);
            end
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end

      S_RM_RD: begin
        re        = 1'b1;
        raddr     = IDX_W'(idx_r);
        state_nxt = S_RM_EVAL;
      end

      S_RM_EVAL: begin
        if (ev.free) begin
          res_st_nxt = ST_BAD_INDEX;
          state_nxt  = S_DONE;
        end else begin
          we          = 1'b1;
          waddr       = IDX_W'(idx_r);
          res_idx_nxt = IDX_W'(idx_r);
          res_cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            // slot frees: drop both present bits, then trim the tail
            wdata     = {2'b00, rdata[WORD_W-3:COUNT_BITS], cnt_dec};
            ra_nxt    = len_r;
            pend_nxt  = 1'b0;
            state_nxt = S_TRIM;
          end else begin
            wdata     = {rdata[WORD_W-1:COUNT_BITS], cnt_dec};
            state_nxt = S_DONE;
          end
        end
      end

      // walk down from the tail while slots are free
      S_TRIM: begin
        if (pend_r) begin
          if (ev.free) begin
            len_nxt = LEN_W'(pidx_r);
          end else begin
            stop = 1'b1;
          end
        end
        if (!stop && (ra_r != '0)) begin
          re       = 1'b1;
          raddr    = IDX_W'(ra_r - LEN_W'(1));
          pend_nxt = 1'b1;
          pidx_nxt = IDX_W'(ra_r - LEN_W'(1));
          ra_nxt   = ra_r - LEN_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_idx_nxt   = SLOT_IDX_W'(res_idx_r);
          out_len_nxt   = TBL_LEN_W'(len_r);
          out_cnt_nxt   = SLOT_CNT_W'(res_cnt_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    key_r     <= key_nxt;
    req_gen_r <= req_gen_nxt;
    idx_r     <= idx_nxt;
    ra_r      <= ra_nxt;
    pidx_r    <= pidx_nxt;
    ffv_r     <= ffv_nxt;
    ff_r      <= ff_nxt;
    res_st_r  <= res_st_nxt;
    res_idx_r <= res_idx_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_st_r  <= out_st_nxt;
    out_idx_r <= out_idx_nxt;
    out_len_r <= out_len_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

// ===== bench/attach_table_checker.sv =====
module attach_table_checker import rat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rat_in_if    in_mon,
  rat_out_if   out_mon,
  output int   fault_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam logic [SLOT_CNT_W-1:0] COUNT_CEIL = '1;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] result_index;
    logic [TBL_LEN_W-1:0]  table_length;
    logic [SLOT_CNT_W-1:0] slot_count;
  } attach_result_t;

  // shadow table
  logic [KEY_W-1:0]      bone_key  [SLOTS];
  logic                  bone_held [SLOTS];
  logic [KEY_W-1:0]      surf_key  [SLOTS];
  logic                  surf_held [SLOTS];
  logic                  gen_mark  [SLOTS];
  logic [SLOT_CNT_W-1:0] uses      [SLOTS];
  int                    live_len;
  int                    faults;
  attach_result_t        awaited_results [$];

  function automatic bit slot_is_free(input int s);
    return !bone_held[s] && !surf_held[s];
  endfunction

  // bump a matching slot, else reuse the lowest free slot, else append
  function automatic attach_result_t attach_key(input bit as_bone, input logic [KEY_W-1:0] k,
                                                input bit gen);
    attach_result_t r;
    int s;
    int spot;
    r = '0;
    r.status = ST_OK;
    for (s = 0; s < live_len; s++) begin
      if (as_bone ? (bone_held[s] && bone_key[s] == k) : (surf_held[s] && surf_key[s] == k)) begin
        if (uses[s] != COUNT_CEIL) uses[s] = uses[s] + 1'b1;
        r.result_index = SLOT_IDX_W'(s);
        r.slot_count   = uses[s];
        return r;
      end
    end
    spot = -1;
    for (s = 0; s < live_len; s++)
      if (spot < 0 && slot_is_free(s)) spot = s;
    if (spot < 0) begin
      if (live_len >= SLOTS) begin
        r.status = ST_FULL;
        return r;
      end
      spot = live_len;
      live_len++;
    end
    bone_held[spot] = as_bone;
    bone_key[spot]  = as_bone ? k : '0;
    surf_held[spot] = !as_bone;
    surf_key[spot]  = as_bone ? '0 : k;
    gen_mark[spot]  = as_bone ? 1'b0 : gen;
    uses[spot]      = SLOT_CNT_W'(1);
    r.result_index  = SLOT_IDX_W'(spot);
    r.slot_count    = SLOT_CNT_W'(1);
    return r;
  endfunction

  function automatic attach_result_t predict_table_op(
    input logic [KIND_W-1:0]     kind,
    input logic [KEY_W-1:0]      key,
    input logic [SCOUNT_W-1:0]   scount,
    input logic                  req_gen,
    input logic [SLOT_IDX_W-1:0] idx
  );
    attach_result_t r;
    int s;
    r = '0;
    case (kind)
      KIND_ADD_GEN: begin
        if ({1'b0, key} >= scount) r.status = ST_SURF_RANGE;
        else r = attach_key(1'b0, key, 1'b1);
      end
      KIND_ADD_SURF: r = attach_key(1'b0, key, 1'b0);
      KIND_ADD_BONE: r = attach_key(1'b1, key, 1'b0);
      KIND_REMOVE: begin
        s = idx;
        if (s >= live_len || slot_is_free(s)) begin
          r.status = ST_BAD_INDEX;
        end else begin
          if (uses[s] != 0) uses[s] = uses[s] - 1'b1;
          if (uses[s] == 0) begin
            bone_held[s] = 1'b0;
            surf_held[s] = 1'b0;
            while (live_len > 0 && slot_is_free(live_len - 1)) live_len--;
          end
          r.status       = ST_OK;
          r.result_index = idx;
          r.slot_count   = uses[s];
        end
      end
      KIND_FIND_BONE, KIND_FIND_SURF: begin
        r.status = ST_NOT_FOUND;
        // walk downwards so the lowest match is the one kept
        for (s = live_len - 1; s >= 0; s--) begin
          if (kind == KIND_FIND_BONE ? (bone_held[s] && bone_key[s] == key)
              : (surf_held[s] && surf_key[s] == key && (!req_gen || gen_mark[s]))) begin
            r.status       = ST_OK;
            r.result_index = SLOT_IDX_W'(s);
            r.slot_count   = uses[s];
          end
        end
      end
      KIND_CLEAR: begin
        live_len = 0;
        r.status = ST_OK;
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.table_length = TBL_LEN_W'(live_len);
    return r;
  endfunction

  task automatic note_fault(input string field, input logic [31:0] want, input logic [31:0] got);
    faults++;
    if (faults <= REPORT_CAP)
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin : monitor
    attach_result_t want;
    attach_result_t fresh;
    if (!rst_n) begin
      live_len = 0;
      awaited_results.delete();
    end else begin
      // result side first, so a result cannot pair with the request taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          faults++;
          if (faults <= REPORT_CAP)
            $error("result transfer with nothing awaited: status %0d index %0d",
                   out_mon.status, out_mon.result_index);
        end else begin
          want = awaited_results.pop_front();
          if (out_mon.status !== want.status)
            note_fault("status", want.status, out_mon.status);
          if (out_mon.result_index !== want.result_index)
            note_fault("result_index", want.result_index, out_mon.result_index);
          if (out_mon.table_length !== want.table_length)
            note_fault("table_length", want.table_length, out_mon.table_length);
          if (out_mon.slot_count !== want.slot_count)
            note_fault("slot_count", want.slot_count, out_mon.slot_count);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        fresh = predict_table_op(in_mon.kind, in_mon.key, in_mon.surface_count,
                                 in_mon.require_generated, in_mon.slot_index);
        awaited_results.insert(awaited_results.size(), fresh);
      end
    end
    outstanding <= awaited_results.size();
    fault_count <= faults;
  end

endmodule

// ===== bench/tb_refcounted_attach_table_core.sv =====
module tb_refcounted_attach_table_core import rat_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // kind code the block does not define; it must come back as a bad index
  localparam logic [KIND_W-1:0] KIND_UNDEFINED = 3'd7;

  localparam int RANDOM_OPS    = 750;
  localparam int BLOCK_OPS     = 50;      // ops per traffic mix
  localparam int REPEAT_ADDS   = 24;      // the same key again and again stacks one use count
  localparam int HOLD_AFTER    = 300;     // result transfers before the long hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 160;     // a full scan plus trim, with margin
  localparam int STALL_LIMIT   = 5000;    // cycles with no transfer on either channel

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_HOT} op_mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rat_in_if  in_ch ();
  rat_out_if out_ch ();

  int fault_count;
  int outstanding;
  int send_idle_pct;
  int recv_idle_pct;

  // keys recently attached, so that lookups and repeat attaches actually land
  bit [KEY_W-1:0] recent_keys [16];
  int             recent_pos;

  refcounted_attach_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  attach_table_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fault_count (fault_count),
    .outstanding (outstanding)
  );

  always #5ns clk = ~clk;

  // Present one request and hold it until the transfer happens. valid is only
  // dropped inside the idle loop, never on the step that raises it again.
  task automatic offer(input int kind, input int key, input int scount, input int req_gen,
                       input int idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.kind              <= KIND_W'(kind);
    in_ch.key               <= KEY_W'(key);
    in_ch.surface_count     <= SCOUNT_W'(scount);
    in_ch.require_generated <= req_gen[0];
    in_ch.slot_index        <= SLOT_IDX_W'(idx);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // One random request shaped by the current traffic mix: growth fills the
  // table up to full, shrink frees and trims, hot hammers a handful of keys.
  task automatic random_op(input op_mix_t mix);
    int roll;
    int add_w;
    int find_w;
    int rem_w;
    int clear_w;
    int kind;
    int key;
    int scount;
    int idx;
    case (mix)
      MIX_GROW:   begin add_w = 78; find_w = 12; rem_w = 6;  clear_w = 0; end
      MIX_SHRINK: begin add_w = 12; find_w = 14; rem_w = 70; clear_w = 0; end
      MIX_MIXED:  begin add_w = 32; find_w = 30; rem_w = 30; clear_w = 3; end
      default:    begin add_w = 35; find_w = 25; rem_w = 35; clear_w = 2; end
    endcase
    roll = $urandom_range(99);
    if (roll < add_w) begin
      case ($urandom_range(2))
        0:       kind = KIND_ADD_GEN;
        1:       kind = KIND_ADD_SURF;
        default: kind = KIND_ADD_BONE;
      endcase
    end else if (roll < add_w + find_w) begin
      kind = $urandom_range(1) ? KIND_FIND_BONE : KIND_FIND_SURF;
    end else if (roll < add_w + find_w + rem_w) begin
      kind = KIND_REMOVE;
    end else if (roll < add_w + find_w + rem_w + clear_w) begin
      kind = KIND_CLEAR;
    end else begin
      kind = KIND_UNDEFINED;
    end

    // finds mostly chase keys already in play; adds mostly bring fresh ones
    if (mix == MIX_HOT)
      key = $urandom_range(7);
    else if ($urandom_range(99) < ((kind == KIND_FIND_BONE || kind == KIND_FIND_SURF) ? 60 : 20))
      key = recent_keys[$urandom_range(15)];
    else
      key = $urandom_range(1023);

    scount = ($urandom_range(99) < 70) ? 1024 : $urandom_range(1024);
    idx    = $urandom_range(1) ? $urandom_range(63) : $urandom_range(15);

    if (kind == KIND_ADD_GEN || kind == KIND_ADD_SURF || kind == KIND_ADD_BONE) begin
      recent_keys[recent_pos] = KEY_W'(key);
      recent_pos = (recent_pos + 1) % 16;
    end
    offer(kind, key, scount, $urandom_range(1), idx);
  endtask

  // Receiver: random ready, plus one long hold-off so the block backs up and
  // stops taking requests while the sender keeps offering.
  initial begin : receiver
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (!held && taken == HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("refcounted_attach_table_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int      n;
    op_mix_t mix;
    in_ch.valid             <= 1'b0;
    in_ch.kind              <= KIND_CLEAR;
    in_ch.key               <= '0;
    in_ch.surface_count     <= '0;
    in_ch.require_generated <= 1'b0;
    in_ch.slot_index        <= '0;
    recent_pos    = 0;
    send_idle_pct = 23;
    recv_idle_pct = 73;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // empty table: nothing to find, nothing to release
    offer(KIND_FIND_BONE, 5, $urandom_range(1024), 1, 0);
    offer(KIND_REMOVE, $urandom_range(1023), $urandom_range(1024), 0, 0);
    // bone append at the top key, then the same key bumps the count
    offer(KIND_ADD_BONE, 1023, 0, 1, 63);
    offer(KIND_ADD_BONE, 1023, 1024, 0, 0);
    // generated surface at the top of the range, then a plain surface add of
    // the same key hits that slot regardless of the mark
    offer(KIND_ADD_GEN, 1023, 1024, 1, 63);
    offer(KIND_ADD_SURF, 1023, 0, 0, 0);
    // surface out of range: key equal to the count, and an empty surface list
    offer(KIND_ADD_GEN, 5, 5, 1, 63);
    offer(KIND_ADD_GEN, 0, 0, 0, 0);
    offer(KIND_ADD_SURF, 0, 1024, 1, 63);
    // surface lookups with and without the generated requirement
    offer(KIND_FIND_SURF, 1023, 0, 1, 0);
    offer(KIND_FIND_SURF, 0, 1024, 1, 63);
    offer(KIND_FIND_SURF, 0, 0, 0, 0);
    offer(KIND_FIND_BONE, 1023, 1024, 1, 63);
    // count down slot 0 to free it, then release it again and one far outside
    offer(KIND_REMOVE, 0, 0, 0, 0);
    offer(KIND_REMOVE, 1023, 1024, 1, 0);
    offer(KIND_REMOVE, 0, 0, 0, 0);
    offer(KIND_REMOVE, 0, 1024, 1, 63);
    offer(KIND_UNDEFINED, 1023, 1024, 1, 63);
    // freed hole below the live length is reused
    offer(KIND_ADD_BONE, 512, 0, 0, 0);
    // freeing the top slots trims the tail
    offer(KIND_REMOVE, 0, 0, 0, 2);
    offer(KIND_REMOVE, 0, 0, 1, 1);
    offer(KIND_REMOVE, 0, 0, 0, 1);
    offer(KIND_CLEAR, 1023, 1024, 1, 63);
    offer(KIND_FIND_BONE, 512, 0, 0, 0);

    // ---- random part, three idling regimes ----
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 23;
      end
      if (n == 2 * RANDOM_OPS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ((n / BLOCK_OPS) % 5)
        0, 1:    mix = MIX_GROW;
        2:       mix = MIX_MIXED;
        3:       mix = MIX_SHRINK;
        default: mix = MIX_HOT;
      endcase
      random_op(mix);
    end

    // ---- repeated attaches of one key on a single-slot table ----
    offer(KIND_CLEAR, 0, 0, 0, 0);
    for (n = 0; n < REPEAT_ADDS; n++)
      offer(KIND_ADD_BONE, 321, $urandom_range(1024), $urandom_range(1), $urandom_range(63));
    offer(KIND_REMOVE, 321, 1024, 0, 0);
    offer(KIND_FIND_BONE, 321, 1024, 1, 63);
    in_ch.valid <= 1'b0;

    // drain: the outstanding count is a registered copy of the checker's queue size
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0)
      $display("refcounted_attach_table_core regression: pass");
    else
      $display("refcounted_attach_table_core regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rat_pkg.sv
rtl/rat_if.sv
rtl/rat_ram.sv
rtl/rat_slot_eval.sv
rtl/refcounted_attach_table_core.sv
bench/attach_table_checker.sv
bench/tb_refcounted_attach_table_core.sv
